// File: hdl/grid_point_scan_generator_top_assert.svh
// Assertion macros for the grid point scan generator checker.
`ifndef GRID_POINT_SCAN_GENERATOR_TOP_ASSERT_SVH
`define GRID_POINT_SCAN_GENERATOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GPSG_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gpsg: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define GPSG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gpsg: next-cycle check failed");

`endif

// File: hdl/gpsg_pkg.sv
`timescale 1ns / 1ps

package gpsg_pkg;

   // Field widths
   localparam int DIM_W      = 13;
   localparam int POS_W      = 12;
   localparam int CELL_W     = 24;
   localparam int STATUS_W   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int WIN_W      = DIM_W + 2;
   localparam int MUL_W      = 2 * DIM_W;
   localparam int DIV_CNT_W  = $clog2(POS_W + 1);

   // Largest image dimension taken as is; larger sizes are clamped
   localparam int MAX_DIM = 4096;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_STARTED        = 4'd0;
   localparam logic [STATUS_W-1:0] ST_KEPT           = 4'd1;
   localparam logic [STATUS_W-1:0] ST_SKIPPED        = 4'd2;
   localparam logic [STATUS_W-1:0] ST_NO_PIXELS      = 4'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_RADIUS     = 4'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_STEP       = 4'd5;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM        = 4'd6;
   localparam logic [STATUS_W-1:0] ST_REGION_OUTSIDE = 4'd7;
   localparam logic [STATUS_W-1:0] ST_NO_POINTS      = 4'd8;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBSET_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_LEFT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_TOP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_RIGHT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BOTTOM = 3'd7;

   // Request type codes
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef struct packed {
      logic req_type;
      logic point_inside;
   } req_data_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    point_x;
      logic [POS_W-1:0]    point_y;
      logic [CELL_W-1:0]   cell_index;
      logic [DIM_W-1:0]    grid_columns;
      logic [DIM_W-1:0]    grid_rows;
      logic [POS_W-1:0]    origin_x;
      logic [POS_W-1:0]    origin_y;
      logic [POS_W-1:0]    next_x;
      logic [POS_W-1:0]    next_y;
      logic                done_res;
   } rsp_data_type;

   // Datapath operation selected by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CHECK,
      OP_DIV_X,
      OP_DIV_Y,
      OP_MUL_X,
      OP_MUL_Y,
      OP_MUL_CELL,
      OP_ADVANCE,
      OP_MUL_NX,
      OP_MUL_NY,
      OP_FIN
   } dp_op_type;

   typedef struct packed {
      logic      accept;
      dp_op_type op;
      logic      div_go;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_active;
      logic refused;
      logic div_done;
   } dp_status_type;

endpackage

// File: hdl/gpsg_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module gpsg_div
   import gpsg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [POS_W-1:0] dividend,
   input  logic [POS_W-1:0] divisor,
   output logic             done,
   output logic [POS_W-1:0] quotient
);

   logic [POS_W:0]       rem_ff, rem_in;
   logic [POS_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [POS_W:0]       trial;
   logic                 fits;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff[POS_W-1:0], quo_ff[POS_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = DIV_CNT_W'(POS_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? trial - {1'b0, divisor} : trial;
         quo_in  = {quo_ff[POS_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/gpsg_dp.sv
`timescale 1ns / 1ps

// Datapath: configuration registers, scan state, window checks, divider,
// shared multiplier and the result register
module gpsg_dp
   import gpsg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  req_data_type          req_data,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output rsp_data_type          rsp_data
);

   // Configuration registers
   logic [DIM_W-1:0]        image_width_ff, image_height_ff;
   logic [POS_W-1:0]        subset_radius_ff, grid_step_ff;
   logic signed [DIM_W-1:0] region_left_ff, region_top_ff;
   logic signed [DIM_W-1:0] region_right_ff, region_bottom_ff;

   // Scan state
   logic             scan_active_ff, scan_active_in;
   logic             region_used_ff, region_used_in;
   logic [DIM_W-1:0] col_count_ff, col_count_in;
   logic [DIM_W-1:0] row_count_ff, row_count_in;
   logic [POS_W-1:0] first_x_ff, first_x_in;
   logic [POS_W-1:0] first_y_ff, first_y_in;
   logic [DIM_W-1:0] cur_col_ff, cur_col_in;
   logic [DIM_W-1:0] cur_row_ff, cur_row_in;
   logic             any_kept_ff, any_kept_in;

   // Working registers of the transaction in flight
   logic                inside_ff, inside_in;
   logic                blank_ff, blank_in;
   logic [POS_W-1:0]    span_x_ff, span_x_in;
   logic [POS_W-1:0]    span_y_ff, span_y_in;
   logic [MUL_W-1:0]    prod_ff;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [POS_W-1:0]    px_ff, px_in, py_ff, py_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   logic [POS_W-1:0]    nx_ff, nx_in, ny_ff, ny_in;
   logic                done_ff, done_in;
   rsp_data_type        rsp_ff, rsp_in;

   // Start checks
   logic [DIM_W-1:0]        img_w, img_h;
   logic signed [WIN_W-1:0] fx0, fy0, lx0, ly0;
   logic signed [WIN_W-1:0] rl, rt, rr, rb;
   logic signed [WIN_W-1:0] fx, fy, lx, ly;
   logic signed [WIN_W-1:0] diff_x, diff_y;
   logic                    box_valid, room_bad, clip_bad;
   logic [STATUS_W-1:0]     check_st;
   logic                    check_fail;

   // Divider and multiplier
   logic             div_done;
   logic [POS_W-1:0] div_quo;
   logic [POS_W-1:0] div_dvd;
   logic [DIM_W-1:0] mul_a, mul_b;

   // Step advance
   logic [DIM_W-1:0] col_inc, col_nxt, row_nxt;
   logic             col_wrap, scan_last, keep, kept_nxt;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= '0;
         image_height_ff  <= '0;
         subset_radius_ff <= POS_W'(1);
         grid_step_ff     <= POS_W'(1);
         region_left_ff   <= '0;
         region_top_ff    <= '0;
         region_right_ff  <= '1;
         region_bottom_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_data;
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_data;
            CSR_SUBSET_RADIUS: subset_radius_ff <= csr_data[POS_W-1:0];
            CSR_GRID_STEP:     grid_step_ff     <= csr_data[POS_W-1:0];
            CSR_REGION_LEFT:   region_left_ff   <= csr_data;
            CSR_REGION_TOP:    region_top_ff    <= csr_data;
            CSR_REGION_RIGHT:  region_right_ff  <= csr_data;
            CSR_REGION_BOTTOM: region_bottom_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Safe window one radius inside the image, clipped to a valid region box
   always_comb begin
      img_w = (image_width_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width_ff;
      img_h = (image_height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height_ff;
      fx0 = $signed({{(WIN_W-POS_W){1'b0}}, subset_radius_ff});
      fy0 = fx0;
      lx0 = $signed({2'b00, img_w}) - WIN_W'(1) - fx0;
      ly0 = $signed({2'b00, img_h}) - WIN_W'(1) - fy0;
      rl  = WIN_W'(region_left_ff);
      rt  = WIN_W'(region_top_ff);
      rr  = WIN_W'(region_right_ff);
      rb  = WIN_W'(region_bottom_ff);
      box_valid = (region_right_ff >= region_left_ff) &&
                  (region_bottom_ff >= region_top_ff);
      room_bad  = (lx0 < fx0) || (ly0 < fy0);
      fx = fx0;
      fy = fy0;
      lx = lx0;
      ly = ly0;
      if (box_valid) begin
         fx = (rl > fx0) ? rl : fx0;
         fy = (rt > fy0) ? rt : fy0;
         lx = (rr < lx0) ? rr : lx0;
         ly = (rb < ly0) ? rb : ly0;
      end
      clip_bad = box_valid && ((lx < fx) || (ly < fy));
      diff_x   = lx - fx;
      diff_y   = ly - fy;
   end

   // Refusal codes in order of the checks
   always_comb begin
      check_fail = 1'b1;
      check_st   = ST_STARTED;
      priority if (img_w == '0 || img_h == '0) begin
         check_st = ST_NO_PIXELS;
      end else if (subset_radius_ff == '0) begin
         check_st = ST_BAD_RADIUS;
      end else if (grid_step_ff == '0) begin
         check_st = ST_BAD_STEP;
      end else if (room_bad) begin
         check_st = ST_NO_ROOM;
      end else if (clip_bad) begin
         check_st = ST_REGION_OUTSIDE;
      end else begin
         check_fail = 1'b0;
      end
   end

   // Column and row counts come from one shared divider
   assign div_dvd = (cmd.op == OP_DIV_Y) ? span_y_ff : span_x_ff;

   gpsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_dvd),
      .divisor  (grid_step_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Shared multiplier operands; product registered every cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_MUL_X, OP_MUL_NX: begin
            mul_a = cur_col_ff;
            mul_b = DIM_W'(grid_step_ff);
         end
         OP_MUL_Y, OP_MUL_NY: begin
            mul_a = cur_row_ff;
            mul_b = DIM_W'(grid_step_ff);
         end
         OP_MUL_CELL: begin
            mul_a = cur_row_ff;
            mul_b = col_count_ff;
         end
         default: ;
      endcase
   end

   // Raster advance of the candidate
   always_comb begin
      col_inc   = cur_col_ff + DIM_W'(1);
      col_wrap  = col_inc >= col_count_ff;
      col_nxt   = col_wrap ? '0 : col_inc;
      row_nxt   = col_wrap ? cur_row_ff + DIM_W'(1) : cur_row_ff;
      scan_last = row_nxt >= row_count_ff;
      keep      = !region_used_ff || inside_ff;
      kept_nxt  = any_kept_ff || keep;
   end

   // Next-state logic of the datapath
   always_comb begin
      scan_active_in = scan_active_ff;
      region_used_in = region_used_ff;
      col_count_in   = col_count_ff;
      row_count_in   = row_count_ff;
      first_x_in     = first_x_ff;
      first_y_in     = first_y_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      any_kept_in    = any_kept_ff;
      inside_in      = inside_ff;
      blank_in       = blank_ff;
      span_x_in      = span_x_ff;
      span_y_in      = span_y_ff;
      st_in          = st_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      cell_in        = cell_ff;
      nx_in          = nx_ff;
      ny_in          = ny_ff;
      done_in        = done_ff;

      // A step while no scan runs answers at once
      if (cmd.accept) begin
         inside_in = req_data.point_inside;
         if (req_data.req_type == REQ_STEP && !scan_active_ff) begin
            st_in    = ST_NO_POINTS;
            blank_in = 1'b1;
            done_in  = 1'b1;
            px_in    = '0;
            py_in    = '0;
            cell_in  = '0;
            nx_in    = '0;
            ny_in    = '0;
         end
      end

      unique case (cmd.op)
         OP_CHECK: begin
            scan_active_in = 1'b0;
            px_in   = '0;
            py_in   = '0;
            cell_in = '0;
            nx_in   = '0;
            ny_in   = '0;
            if (check_fail) begin
               st_in    = check_st;
               blank_in = 1'b1;
               done_in  = 1'b1;
            end else begin
               blank_in       = 1'b0;
               done_in        = 1'b0;
               region_used_in = box_valid;
               first_x_in     = fx[POS_W-1:0];
               first_y_in     = fy[POS_W-1:0];
               span_x_in      = diff_x[POS_W-1:0];
               span_y_in      = diff_y[POS_W-1:0];
            end
         end
         OP_DIV_X: begin
            if (div_done) begin
               col_count_in = DIM_W'(div_quo) + DIM_W'(1);
            end
         end
         OP_DIV_Y: begin
            if (div_done) begin
               row_count_in   = DIM_W'(div_quo) + DIM_W'(1);
               cur_col_in     = '0;
               cur_row_in     = '0;
               any_kept_in    = 1'b0;
               scan_active_in = 1'b1;
               st_in          = ST_STARTED;
               nx_in          = first_x_ff;
               ny_in          = first_y_ff;
            end
         end
         OP_MUL_Y: begin
            px_in = first_x_ff + prod_ff[POS_W-1:0];
         end
         OP_MUL_CELL: begin
            py_in = first_y_ff + prod_ff[POS_W-1:0];
         end
         OP_ADVANCE: begin
            cell_in     = prod_ff[CELL_W-1:0] + CELL_W'(cur_col_ff);
            any_kept_in = kept_nxt;
            cur_col_in  = col_nxt;
            cur_row_in  = row_nxt;
            blank_in    = 1'b0;
            nx_in       = '0;
            ny_in       = '0;
            done_in     = scan_last;
            if (scan_last) begin
               scan_active_in = 1'b0;
            end
            if (scan_last && !kept_nxt) begin
               st_in = ST_NO_POINTS;
            end else begin
               st_in = keep ? ST_KEPT : ST_SKIPPED;
            end
         end
         OP_MUL_NY: begin
            nx_in = first_x_ff + prod_ff[POS_W-1:0];
         end
         OP_FIN: begin
            ny_in = first_y_ff + prod_ff[POS_W-1:0];
         end
         OP_NONE, OP_MUL_X, OP_MUL_NX: ;
         default: ;
      endcase
   end

   // Result register contents
   always_comb begin
      rsp_in.status       = st_ff;
      rsp_in.point_x      = px_ff;
      rsp_in.point_y      = py_ff;
      rsp_in.cell_index   = cell_ff;
      rsp_in.grid_columns = blank_ff ? '0 : col_count_ff;
      rsp_in.grid_rows    = blank_ff ? '0 : row_count_ff;
      rsp_in.origin_x     = blank_ff ? '0 : first_x_ff;
      rsp_in.origin_y     = blank_ff ? '0 : first_y_ff;
      rsp_in.next_x       = nx_ff;
      rsp_in.next_y       = ny_ff;
      rsp_in.done_res     = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
         region_used_ff <= 1'b0;
         col_count_ff   <= '0;
         row_count_ff   <= '0;
         first_x_ff     <= '0;
         first_y_ff     <= '0;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         any_kept_ff    <= 1'b0;
         blank_ff       <= 1'b0;
      end else begin
         scan_active_ff <= scan_active_in;
         region_used_ff <= region_used_in;
         col_count_ff   <= col_count_in;
         row_count_ff   <= row_count_in;
         first_x_ff     <= first_x_in;
         first_y_ff     <= first_y_in;
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         any_kept_ff    <= any_kept_in;
         blank_ff       <= blank_in;
      end
      inside_ff <= inside_in;
      span_x_ff <= span_x_in;
      span_y_ff <= span_y_in;
      prod_ff   <= mul_a * mul_b;
      st_ff     <= st_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      cell_ff   <= cell_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      done_ff   <= done_in;
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.scan_active = scan_active_ff;
   assign status.refused     = blank_ff;
   assign status.div_done    = div_done;
   assign rsp_data           = rsp_ff;

endmodule

// File: hdl/gpsg_ctrl.sv
`timescale 1ns / 1ps

// Controller: sequences start and step transactions through the datapath
module gpsg_ctrl
   import gpsg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_is_step,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_CHECK    = 14'b00000000000010,
      S_DIVX_GO  = 14'b00000000000100,
      S_DIVX_RUN = 14'b00000000001000,
      S_DIVY_GO  = 14'b00000000010000,
      S_DIVY_RUN = 14'b00000000100000,
      S_MUL_X    = 14'b00000001000000,
      S_MUL_Y    = 14'b00000010000000,
      S_MUL_CELL = 14'b00000100000000,
      S_ADVANCE  = 14'b00001000000000,
      S_MUL_NX   = 14'b00010000000000,
      S_MUL_NY   = 14'b00100000000000,
      S_FIN      = 14'b01000000000000,
      S_RESULT   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Result register can take a new transaction
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = 1'b0;
      cmd.op       = OP_NONE;
      cmd.div_go   = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!req_is_step) begin
                  state_in = S_CHECK;
               end else if (status.scan_active) begin
                  state_in = S_MUL_X;
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = S_DIVX_GO;
         end
         S_DIVX_GO: begin
            cmd.op = OP_DIV_X;
            if (status.refused) begin
               state_in = S_RESULT;
            end else begin
               cmd.div_go = 1'b1;
               state_in   = S_DIVX_RUN;
            end
         end
         S_DIVX_RUN: begin
            cmd.op = OP_DIV_X;
            if (status.div_done) begin
               state_in = S_DIVY_GO;
            end
         end
         S_DIVY_GO: begin
            cmd.op     = OP_DIV_Y;
            cmd.div_go = 1'b1;
            state_in   = S_DIVY_RUN;
         end
         S_DIVY_RUN: begin
            cmd.op = OP_DIV_Y;
            if (status.div_done) begin
               state_in = S_RESULT;
            end
         end
         S_MUL_X: begin
            cmd.op   = OP_MUL_X;
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            cmd.op   = OP_MUL_Y;
            state_in = S_MUL_CELL;
         end
         S_MUL_CELL: begin
            cmd.op   = OP_MUL_CELL;
            state_in = S_ADVANCE;
         end
         S_ADVANCE: begin
            cmd.op   = OP_ADVANCE;
            state_in = S_MUL_NX;
         end
         S_MUL_NX: begin
            // scan over after the advance: no next candidate to place
            cmd.op   = OP_MUL_NX;
            state_in = status.scan_active ? S_MUL_NY : S_RESULT;
         end
         S_MUL_NY: begin
            cmd.op   = OP_MUL_NY;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = OP_FIN;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid: set on load, cleared once the transaction is taken
   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/grid_point_scan_generator_top.sv
// Transactions: a start runs two 12-bit divisions on one bit-serial divider, a step
// uses one shared multiplier five times, a final step places no next candidate, and a
// refused start or a step with no scan running skips the arithmetic.
// One transaction in flight; the next is accepted the cycle after its result is loaded.
// Synchronous active-high reset: scan idle, registers at their reset values.
`timescale 1ns / 1ps

module grid_point_scan_generator_top
   import gpsg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   gpsg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_step (req_data.req_type),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   gpsg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/gpsg_checker.sv
`timescale 1ns / 1ps

`include "grid_point_scan_generator_top_assert.svh"

// Port-level checks of the scan generator
module gpsg_checker
   import gpsg_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   // Stalled result transaction holds
   `GPSG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // One transaction at a time: an accepted request closes the input
   `GPSG_ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall)

   // A new result only follows work on a request
   `GPSG_ASSERT_SAME(a_rsp_after_req, $rose(rsp_valid), $past(req_stall))

   // Refusals and no-points always end the scan
   `GPSG_ASSERT_SAME(a_refusal_done,
      rsp_valid && !(rsp_data.status == ST_STARTED || rsp_data.status == ST_KEPT ||
                     rsp_data.status == ST_SKIPPED),
      rsp_data.done_res)

endmodule

bind grid_point_scan_generator_top gpsg_checker u_gpsg_checker (.*);

// File: tb/grid_point_scan_generator_top_tb.sv
`timescale 1ns / 1ps

module grid_point_scan_generator_top_tb;
   import gpsg_pkg::*;

   // Directed plan row: either a register write or a request
   typedef enum logic {ROW_CSR, ROW_REQ} row_op_type;

   typedef struct {
      row_op_type            op;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] value;
      req_data_type          req;
      bit                    has_fixed;
      rsp_data_type          fixed;
   } plan_row_type;

   // How the inside-test answers are chosen over one scan
   typedef enum logic [1:0] {HIT_NONE, HIT_ALL, HIT_MIXED} hit_mode_type;

   // Receiver stall patterns
   typedef enum logic [1:0] {STALL_OFF, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   localparam logic [CSR_IDX_W-1:0] REG_ORDER [8] = '{
      CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_SUBSET_RADIUS, CSR_GRID_STEP,
      CSR_REGION_LEFT, CSR_REGION_TOP, CSR_REGION_RIGHT, CSR_REGION_BOTTOM
   };

   localparam int RANDOM_ITEMS = 1850;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_data_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_data_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Register shadow
   logic [DIM_W-1:0]        cfg_width;
   logic [DIM_W-1:0]        cfg_height;
   logic [POS_W-1:0]        cfg_radius;
   logic [POS_W-1:0]        cfg_step;
   logic signed [DIM_W-1:0] cfg_left;
   logic signed [DIM_W-1:0] cfg_top;
   logic signed [DIM_W-1:0] cfg_right;
   logic signed [DIM_W-1:0] cfg_bottom;

   // Scan state shadow
   logic             scan_on;
   logic             box_on;
   logic [DIM_W-1:0] scan_cols;
   logic [DIM_W-1:0] scan_rows;
   logic [POS_W-1:0] org_x;
   logic [POS_W-1:0] org_y;
   logic [DIM_W-1:0] col_pos;
   logic [DIM_W-1:0] row_pos;
   logic             kept_any;

   rsp_data_type pending_results[$];
   int           mismatch_count;
   int           sent_items;
   int           burst_left;

   grid_point_scan_generator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Register shadow update on an accepted write
   task automatic apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_IMAGE_WIDTH:   cfg_width  = val;
         CSR_IMAGE_HEIGHT:  cfg_height = val;
         CSR_SUBSET_RADIUS: cfg_radius = val[POS_W-1:0];
         CSR_GRID_STEP:     cfg_step   = val[POS_W-1:0];
         CSR_REGION_LEFT:   cfg_left   = val;
         CSR_REGION_TOP:    cfg_top    = val;
         CSR_REGION_RIGHT:  cfg_right  = val;
         default:           cfg_bottom = val;
      endcase
   endtask

   // Expected result of one request; advances the scan shadow
   function automatic rsp_data_type predict_scan_result(req_data_type d);
      rsp_data_type o;
      int           w, h, rad, stp, fx, fy, lx, ly, rl, rt, rr, rb, px, py, cell_no;
      logic         keep;
      o = '0;
      if (d.req_type == REQ_START) begin
         scan_on = 1'b0;
         o.done_res = 1'b1;
         w   = (int'(cfg_width) > MAX_DIM) ? MAX_DIM : int'(cfg_width);
         h   = (int'(cfg_height) > MAX_DIM) ? MAX_DIM : int'(cfg_height);
         rad = int'(cfg_radius);
         stp = int'(cfg_step);
         rl  = int'(cfg_left);
         rt  = int'(cfg_top);
         rr  = int'(cfg_right);
         rb  = int'(cfg_bottom);
         if (w == 0 || h == 0) begin
            o.status = ST_NO_PIXELS;
         end else if (rad == 0) begin
            o.status = ST_BAD_RADIUS;
         end else if (stp == 0) begin
            o.status = ST_BAD_STEP;
         end else begin
            // safe window one radius inside each edge
            fx = rad;
            fy = rad;
            lx = w - 1 - rad;
            ly = h - 1 - rad;
            if (lx < fx || ly < fy) begin
               o.status = ST_NO_ROOM;
            end else begin
               box_on = (rr >= rl) && (rb >= rt);
               if (box_on) begin
                  fx = (rl > fx) ? rl : fx;
                  fy = (rt > fy) ? rt : fy;
                  lx = (rr < lx) ? rr : lx;
                  ly = (rb < ly) ? rb : ly;
               end
               if (lx < fx || ly < fy) begin
                  o.status = ST_REGION_OUTSIDE;
               end else begin
                  scan_cols = DIM_W'((lx - fx) / stp + 1);
                  scan_rows = DIM_W'((ly - fy) / stp + 1);
                  org_x     = POS_W'(fx);
                  org_y     = POS_W'(fy);
                  col_pos   = '0;
                  row_pos   = '0;
                  kept_any  = 1'b0;
                  scan_on   = 1'b1;
                  o.status       = ST_STARTED;
                  o.done_res     = 1'b0;
                  o.grid_columns = scan_cols;
                  o.grid_rows    = scan_rows;
                  o.origin_x     = org_x;
                  o.origin_y     = org_y;
                  o.next_x       = org_x;
                  o.next_y       = org_y;
               end
            end
         end
      end else if (!scan_on) begin
         o.status   = ST_NO_POINTS;
         o.done_res = 1'b1;
      end else begin
         // positions follow the live step register
         px      = int'(org_x) + int'(col_pos) * int'(cfg_step);
         py      = int'(org_y) + int'(row_pos) * int'(cfg_step);
         cell_no = int'(row_pos) * int'(scan_cols) + int'(col_pos);
         keep = !box_on || d.point_inside;
         if (keep) kept_any = 1'b1;
         o.status       = keep ? ST_KEPT : ST_SKIPPED;
         o.point_x      = px[POS_W-1:0];
         o.point_y      = py[POS_W-1:0];
         o.cell_index   = cell_no[CELL_W-1:0];
         o.grid_columns = scan_cols;
         o.grid_rows    = scan_rows;
         o.origin_x     = org_x;
         o.origin_y     = org_y;
         col_pos = col_pos + 1'b1;
         if (col_pos >= scan_cols) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
         end
         if (row_pos >= scan_rows) begin
            // last candidate of the scan
            o.done_res = 1'b1;
            scan_on    = 1'b0;
            if (!kept_any) o.status = ST_NO_POINTS;
         end else begin
            px = int'(org_x) + int'(col_pos) * int'(cfg_step);
            py = int'(org_y) + int'(row_pos) * int'(cfg_step);
            o.next_x = px[POS_W-1:0];
            o.next_y = py[POS_W-1:0];
         end
      end
      return o;
   endfunction

   function automatic rsp_data_type fixed_result(
      logic [STATUS_W-1:0] st, int px, int py, int cell_no, int cols, int rows,
      int ox, int oy, int nx, int ny, logic done);
      rsp_data_type o;
      o.status       = st;
      o.point_x      = POS_W'(px);
      o.point_y      = POS_W'(py);
      o.cell_index   = CELL_W'(cell_no);
      o.grid_columns = DIM_W'(cols);
      o.grid_rows    = DIM_W'(rows);
      o.origin_x     = POS_W'(ox);
      o.origin_y     = POS_W'(oy);
      o.next_x       = POS_W'(nx);
      o.next_y       = POS_W'(ny);
      o.done_res     = done;
      return o;
   endfunction

   function automatic rsp_data_type refusal(logic [STATUS_W-1:0] st);
      return fixed_result(st, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] val);
      plan_row_type p;
      p = '{op: ROW_CSR, idx: idx, value: val, req: '0, has_fixed: 1'b0, fixed: '0};
      return p;
   endfunction

   function automatic plan_row_type req_row(logic t, logic ins, bit has_fixed,
                                            rsp_data_type fixed);
      plan_row_type p;
      p = '{op: ROW_REQ, idx: '0, value: '0, req: '{req_type: t, point_inside: ins},
            has_fixed: has_fixed, fixed: fixed};
      return p;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] sat13(int v);
      if (v < -4096) v = -4096;
      else if (v > 4095) v = 4095;
      return v[CSR_DATA_W-1:0];
   endfunction

   // Register write; only issued with no transaction outstanding
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      if (req_valid) req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, val);
   endtask

   // Request transaction with bursty sender gaps
   task automatic send_req(req_data_type d, bit has_fixed, rsp_data_type fixed);
      rsp_data_type pred;
      int           gap;
      if (csr_valid) csr_valid <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = predict_scan_result(d);
      pending_results.push_back(has_fixed ? fixed : pred);
      sent_items++;
   endtask

   task automatic compare_field(string name, logic [CELL_W-1:0] e, logic [CELL_W-1:0] a);
      if (e !== a) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, got status %0d",
                     $time, rsp_data.status);
         end else begin
            rsp_data_type e;
            e = pending_results.pop_front();
            compare_field("status", CELL_W'(e.status), CELL_W'(rsp_data.status));
            compare_field("point_x", CELL_W'(e.point_x), CELL_W'(rsp_data.point_x));
            compare_field("point_y", CELL_W'(e.point_y), CELL_W'(rsp_data.point_y));
            compare_field("cell_index", e.cell_index, rsp_data.cell_index);
            compare_field("grid_columns", CELL_W'(e.grid_columns),
                          CELL_W'(rsp_data.grid_columns));
            compare_field("grid_rows", CELL_W'(e.grid_rows), CELL_W'(rsp_data.grid_rows));
            compare_field("origin_x", CELL_W'(e.origin_x), CELL_W'(rsp_data.origin_x));
            compare_field("origin_y", CELL_W'(e.origin_y), CELL_W'(rsp_data.origin_y));
            compare_field("next_x", CELL_W'(e.next_x), CELL_W'(rsp_data.next_x));
            compare_field("next_y", CELL_W'(e.next_y), CELL_W'(rsp_data.next_y));
            compare_field("done_res", CELL_W'(e.done_res), CELL_W'(rsp_data.done_res));
         end
      end
   end

   // Receiver stall patterns, with long hold-offs to back up the block
   initial begin
      int unsigned    cyc;
      int unsigned    mode_left;
      int unsigned    hold_left;
      stall_mode_type mode;
      rsp_stall = 1'b0;
      cyc       = 0;
      mode_left = 0;
      hold_left = 0;
      mode      = STALL_OFF;
      forever begin
         @(posedge clock);
         cyc++;
         if ((cyc % 4000) == 3000) hold_left = 250;
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               STALL_OFF:   rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Stimulus
   initial begin
      plan_row_type          plan[$];
      req_data_type          d;
      logic [CSR_DATA_W-1:0] regs [8];
      hit_mode_type          hit;
      int rand_base, s, r, nc, nr, w, h, rl, rt, rr, rb, span_x, span_y;
      int pick, steps, total, change_at;

      mismatch_count = 0;
      sent_items     = 0;
      burst_left     = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data  <= '0;

      // shadow at reset
      cfg_width  = '0;
      cfg_height = '0;
      cfg_radius = 12'd1;
      cfg_step   = 12'd1;
      cfg_left   = '0;
      cfg_top    = '0;
      cfg_right  = '1;
      cfg_bottom = '1;
      scan_on    = 1'b0;
      box_on     = 1'b0;
      scan_cols  = '0;
      scan_rows  = '0;
      org_x      = '0;
      org_y      = '0;
      col_pos    = '0;
      row_pos    = '0;
      kept_any   = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed plan
      // step with no scan, then start with the reset (zero) image size
      plan.push_back(req_row(REQ_STEP, 1'b1, 1'b1, refusal(ST_NO_POINTS)));
      plan.push_back(req_row(REQ_START, 1'b0, 1'b1, refusal(ST_NO_PIXELS)));
      // oversized width, zero height
      plan.push_back(csr_row(CSR_IMAGE_WIDTH, 13'h1FFF));
      plan.push_back(csr_row(CSR_IMAGE_HEIGHT, 13'd0));
      plan.push_back(req_row(REQ_START, 1'b1, 1'b1, refusal(ST_NO_PIXELS)));
      plan.push_back(csr_row(CSR_IMAGE_HEIGHT, 13'd20));
      plan.push_back(csr_row(CSR_SUBSET_RADIUS, 13'd0));
      plan.push_back(req_row(REQ_START, 1'b0, 1'b1, refusal(ST_BAD_RADIUS)));
      plan.push_back(csr_row(CSR_SUBSET_RADIUS, 13'd4095));
      plan.push_back(csr_row(CSR_GRID_STEP, 13'd0));
      plan.push_back(req_row(REQ_START, 1'b0, 1'b1, refusal(ST_BAD_STEP)));
      plan.push_back(csr_row(CSR_GRID_STEP, 13'd1));
      plan.push_back(req_row(REQ_START, 1'b0, 1'b1, refusal(ST_NO_ROOM)));
      // clamped 4096-wide image, no region: one long row
      plan.push_back(csr_row(CSR_SUBSET_RADIUS, 13'd2));
      plan.push_back(csr_row(CSR_IMAGE_HEIGHT, 13'd5));
      plan.push_back(req_row(REQ_START, 1'b0, 1'b1,
                             fixed_result(ST_STARTED, 0, 0, 0, 4092, 1, 2, 2, 2, 2, 1'b0)));
      plan.push_back(req_row(REQ_STEP, 1'b0, 1'b1,
                             fixed_result(ST_KEPT, 2, 2, 0, 4092, 1, 2, 2, 3, 2, 1'b0)));
      plan.push_back(req_row(REQ_STEP, 1'b1, 1'b0, '0));
      // widest region box, coarse step: skip, keep, then end of scan
      plan.push_back(csr_row(CSR_REGION_LEFT, 13'h1000));
      plan.push_back(csr_row(CSR_REGION_TOP, 13'h1000));
      plan.push_back(csr_row(CSR_REGION_RIGHT, 13'h0FFF));
      plan.push_back(csr_row(CSR_REGION_BOTTOM, 13'h0FFF));
      plan.push_back(csr_row(CSR_GRID_STEP, 13'd2045));
      plan.push_back(req_row(REQ_START, 1'b0, 1'b0, '0));
      plan.push_back(req_row(REQ_STEP, 1'b0, 1'b0, '0));
      plan.push_back(req_row(REQ_STEP, 1'b1, 1'b0, '0));
      plan.push_back(req_row(REQ_STEP, 1'b0, 1'b0, '0));
      plan.push_back(req_row(REQ_STEP, 1'b1, 1'b1, refusal(ST_NO_POINTS)));
      // region clear of the safe window
      plan.push_back(csr_row(CSR_REGION_LEFT, 13'h0FFF));
      plan.push_back(req_row(REQ_START, 1'b0, 1'b1, refusal(ST_REGION_OUTSIDE)));
      // single-point scan where nothing is kept
      plan.push_back(csr_row(CSR_IMAGE_WIDTH, 13'd3));
      plan.push_back(csr_row(CSR_IMAGE_HEIGHT, 13'd3));
      plan.push_back(csr_row(CSR_SUBSET_RADIUS, 13'd1));
      plan.push_back(csr_row(CSR_REGION_LEFT, 13'd0));
      plan.push_back(req_row(REQ_START, 1'b0, 1'b1,
                             fixed_result(ST_STARTED, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1'b0)));
      plan.push_back(req_row(REQ_STEP, 1'b0, 1'b1,
                             fixed_result(ST_NO_POINTS, 1, 1, 0, 1, 1, 1, 1, 0, 0, 1'b1)));

      foreach (plan[i]) begin
         if (plan[i].op == ROW_CSR) write_csr(plan[i].idx, plan[i].value);
         else send_req(plan[i].req, plan[i].has_fixed, plan[i].fixed);
      end

      // Random scans: mostly well-formed geometry with random answers
      rand_base = sent_items;
      while (sent_items - rand_base < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         s = (pick < 70) ? $urandom_range(1, 12) :
             (pick < 90) ? $urandom_range(13, 600) : $urandom_range(601, 4095);
         pick = $urandom_range(0, 99);
         r = (pick < 60) ? $urandom_range(1, 8) :
             (pick < 90) ? $urandom_range(9, 300) : $urandom_range(301, 2047);
         nc = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         nr = $urandom_range(1, 6);
         span_x = (nc - 1) * s;
         span_y = (nr - 1) * s;
         w = 2 * r + span_x + 1 + int'($urandom_range(0, s - 1));
         h = 2 * r + span_y + 1 + int'($urandom_range(0, s - 1));
         if (w > 8191) w = $urandom_range(4096, 8191);
         if (h > 8191) h = $urandom_range(4096, 8191);

         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // box with one axis reversed: no region
            rl = $urandom_range(0, 300);
            rt = $urandom_range(0, 300);
            if ($urandom_range(0, 1) == 1) begin
               rr = rl - 1 - int'($urandom_range(0, 50));
               rb = rt + int'($urandom_range(0, 500));
            end else begin
               rr = rl + int'($urandom_range(0, 500));
               rb = rt - 1 - int'($urandom_range(0, 50));
            end
         end else if (pick < 85) begin
            // box overlapping the safe window
            rl = r - int'($urandom_range(0, s)) + int'($urandom_range(0, span_x));
            rt = r - int'($urandom_range(0, s)) + int'($urandom_range(0, span_y));
            rr = rl + int'($urandom_range(0, span_x + s));
            rb = rt + int'($urandom_range(0, span_y + s));
         end else begin
            rl = int'($urandom_range(0, 8191)) - 4096;
            rt = int'($urandom_range(0, 8191)) - 4096;
            rr = int'($urandom_range(0, 8191)) - 4096;
            rb = int'($urandom_range(0, 8191)) - 4096;
         end

         regs[CSR_IMAGE_WIDTH]   = CSR_DATA_W'(w);
         regs[CSR_IMAGE_HEIGHT]  = CSR_DATA_W'(h);
         regs[CSR_SUBSET_RADIUS] = CSR_DATA_W'(r);
         regs[CSR_GRID_STEP]     = CSR_DATA_W'(s);
         regs[CSR_REGION_LEFT]   = sat13(rl);
         regs[CSR_REGION_TOP]    = sat13(rt);
         regs[CSR_REGION_RIGHT]  = sat13(rr);
         regs[CSR_REGION_BOTTOM] = sat13(rb);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            foreach (regs[i]) regs[i] = CSR_DATA_W'($urandom_range(0, 8191));
         end else if (pick < 15) begin
            regs[REG_ORDER[$urandom_range(0, 3)]] = '0;
         end
         for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 9) != 0) write_csr(REG_ORDER[i], regs[REG_ORDER[i]]);
         end

         // occasional stray step ahead of the start
         if ($urandom_range(0, 9) == 0) begin
            d.req_type     = REQ_STEP;
            d.point_inside = 1'($urandom_range(0, 1));
            send_req(d, 1'b0, '0);
         end
         d.req_type     = REQ_START;
         d.point_inside = 1'($urandom_range(0, 1));
         send_req(d, 1'b0, '0);

         // walk the scan to its end, past it, or abandon it part way
         if (scan_on) begin
            total = int'(scan_cols) * int'(scan_rows);
            steps = total + int'($urandom_range(0, 2));
            if (steps > 60 || $urandom_range(0, 6) == 0)
               steps = $urandom_range(1, (total < 60) ? total : 60);
         end else begin
            steps = $urandom_range(0, 2);
         end
         change_at = (steps >= 2 && $urandom_range(0, 9) == 0) ? steps / 2 : -1;
         pick = $urandom_range(0, 99);
         hit = (pick < 20) ? HIT_NONE : (pick < 40) ? HIT_ALL : HIT_MIXED;
         for (int k = 0; k < steps; k++) begin
            // step register changed while a scan is running
            if (k == change_at)
               write_csr(CSR_GRID_STEP, CSR_DATA_W'($urandom_range(0, 4095)));
            d.req_type = REQ_STEP;
            case (hit)
               HIT_NONE: d.point_inside = 1'b0;
               HIT_ALL:  d.point_inside = 1'b1;
               default:  d.point_inside = 1'($urandom_range(0, 1));
            endcase
            send_req(d, 1'b0, '0);
         end
      end

      // Drain
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/gpsg_pkg.sv
hdl/gpsg_div.sv
hdl/gpsg_dp.sv
hdl/gpsg_ctrl.sv
hdl/grid_point_scan_generator_top.sv
hdl/gpsg_checker.sv
tb/grid_point_scan_generator_top_tb.sv
